/* src/debounce_edge_auto_repeat_assert.svh */
// Assertion helpers shared by the block's RTL.
`ifndef DEBOUNCE_EDGE_AUTO_REPEAT_ASSERT_SVH
`define DEBOUNCE_EDGE_AUTO_REPEAT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define DEAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dear: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define DEAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dear: next-cycle check failed");

`endif

/* src/dear_pkg.sv */
package dear_pkg;

  localparam int TIME_W     = 32;
  localparam int NUM_ACT    = 4;
  localparam int ACT_W      = 2;
  localparam int DBC_W      = 8;
  localparam int DLY_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [DBC_W-1:0] K_DEBOUNCE_MS  = 8'd8;
  localparam logic [DLY_W-1:0] K_FIRST_DELAY  = 16'd500;
  localparam logic [DLY_W-1:0] K_REPEAT_IVL   = 16'd150;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL  = 2'd2;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_WAS    = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;
  localparam logic [1:0] MODE_IS     = 2'd3;

  // stick codes
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  // action slots
  localparam int ACT_UP   = 0;
  localparam int ACT_DOWN = 1;
  localparam int ACT_OK   = 2;
  localparam int ACT_BACK = 3;

  typedef logic [TIME_W-1:0] time_t;

endpackage

/* src/debounce_edge_auto_repeat.sv */
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_ready  mode, direction, switch_pressed, action, now_ms
// out_     out  out_valid/out_ready answer
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while out_ready is high. An accepted word passes the
// input register, then the state update and answer register, which raises out_valid.
// rst_n is synchronous: all per-action state clears to zero, registers to defaults.
// A stalled out_ holds its word; in_ still takes one more word into the input register.
// cfg_ready is always high; writes to an unused index are dropped.
module debounce_edge_auto_repeat (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [2:0]                        in_direction,
  input  logic                              in_switch_pressed,
  input  logic [dear_pkg::ACT_W-1:0]        in_action,
  input  logic [dear_pkg::TIME_W-1:0]       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_answer,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dear_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dear_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dear_pkg::*;

  `include "debounce_edge_auto_repeat_assert.svh"

  logic [DBC_W-1:0] dbc_r;
  logic [DLY_W-1:0] first_dly_r;
  logic [DLY_W-1:0] rep_ivl_r;

  logic              s0_valid_r;
  logic [1:0]        s0_mode_r;
  logic [2:0]        s0_dir_r;
  logic              s0_sw_r;
  logic [ACT_W-1:0]  s0_act_r;
  time_t             s0_now_r;

  logic              out_valid_r;
  logic              out_answer_r;

  logic [NUM_ACT-1:0] stable_r, stable_nxt;
  logic [NUM_ACT-1:0] last_raw_r, last_raw_nxt;
  logic [NUM_ACT-1:0] edge_r, edge_nxt;
  time_t              chg_time_r [NUM_ACT];
  time_t              chg_time_nxt [NUM_ACT];
  time_t              press_time_r [NUM_ACT];
  time_t              press_time_nxt [NUM_ACT];
  time_t              fire_time_r [NUM_ACT];
  time_t              fire_time_nxt [NUM_ACT];

  logic               s0_adv, s0_fire, in_fire, ans;
  logic [NUM_ACT-1:0] raw;
  logic [NUM_ACT-1:0] act_oh;
  time_t              since_press, since_fire;

  assign in_fire   = in_valid && in_ready;
  assign s0_adv    = !out_valid_r || out_ready;
  assign s0_fire   = s0_valid_r && s0_adv;
  assign in_ready  = !s0_valid_r || s0_adv;
  assign out_valid = out_valid_r;
  assign out_answer = out_answer_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    raw[ACT_UP]   = (s0_dir_r == DIR_UP);
    raw[ACT_DOWN] = (s0_dir_r == DIR_DOWN);
    raw[ACT_OK]   = (s0_dir_r == DIR_RIGHT) || s0_sw_r;
    raw[ACT_BACK] = (s0_dir_r == DIR_LEFT);
    act_oh = '0;
    act_oh[s0_act_r] = 1'b1;
  end

  assign since_press = s0_now_r - press_time_r[s0_act_r];
  assign since_fire  = s0_now_r - fire_time_r[s0_act_r];

  always_comb begin
    stable_nxt     = stable_r;
    last_raw_nxt   = last_raw_r;
    edge_nxt       = edge_r;
    chg_time_nxt   = chg_time_r;
    press_time_nxt = press_time_r;
    fire_time_nxt  = fire_time_r;
    ans            = 1'b0;
    if (s0_fire) begin
      unique case (s0_mode_r)
        MODE_SAMPLE: begin
          for (int i = 0; i < NUM_ACT; i++) begin
            if (raw[i] != last_raw_r[i]) begin
              last_raw_nxt[i] = raw[i];
              chg_time_nxt[i] = s0_now_r;
            end else if ((s0_now_r - chg_time_r[i]) >=
                         {{(TIME_W-DBC_W){1'b0}}, dbc_r}) begin
              if (raw[i] != stable_r[i]) begin
                stable_nxt[i] = raw[i];
                if (raw[i]) begin
                  edge_nxt[i]       = 1'b1;
                  press_time_nxt[i] = s0_now_r;
                  fire_time_nxt[i]  = s0_now_r;
                end
              end
            end
          end
        end
        MODE_WAS: begin
          if (edge_r[s0_act_r]) begin
            edge_nxt[s0_act_r] = 1'b0;
            ans = 1'b1;
          end
        end
        MODE_REPEAT: begin
          if (edge_r[s0_act_r]) begin
            edge_nxt[s0_act_r]      = 1'b0;
            fire_time_nxt[s0_act_r] = s0_now_r;
            ans = 1'b1;
          end else if (stable_r[s0_act_r]
                       && since_press >= {{(TIME_W-DLY_W){1'b0}}, first_dly_r}
                       && since_fire  >= {{(TIME_W-DLY_W){1'b0}}, rep_ivl_r}) begin
            fire_time_nxt[s0_act_r] = s0_now_r;
            ans = 1'b1;
          end
        end
        MODE_IS: ans = stable_r[s0_act_r];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbc_r       <= K_DEBOUNCE_MS;
      first_dly_r <= K_FIRST_DELAY;
      rep_ivl_r   <= K_REPEAT_IVL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:    dbc_r       <= cfg_data[DBC_W-1:0];
        CFG_FIRST_DELAY: first_dly_r <= cfg_data[DLY_W-1:0];
        CFG_REPEAT_IVL:  rep_ivl_r   <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)
        s0_valid_r <= 1'b1;
      else if (s0_fire)
        s0_valid_r <= 1'b0;
      if (s0_fire)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_mode_r <= in_mode;
      s0_dir_r  <= in_direction;
      s0_sw_r   <= in_switch_pressed;
      s0_act_r  <= in_action;
      s0_now_r  <= in_now_ms;
    end
    if (s0_fire)
      out_answer_r <= ans;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r   <= '0;
      last_raw_r <= '0;
      edge_r     <= '0;
      for (int i = 0; i < NUM_ACT; i++) begin
        chg_time_r[i]   <= '0;
        press_time_r[i] <= '0;
        fire_time_r[i]  <= '0;
      end
    end else begin
      stable_r     <= stable_nxt;
      last_raw_r   <= last_raw_nxt;
      edge_r       <= edge_nxt;
      chg_time_r   <= chg_time_nxt;
      press_time_r <= press_time_nxt;
      fire_time_r  <= fire_time_nxt;
    end
  end

  // sample words always answer 0
  `DEAR_ASSERT_NEXT(a_sample_zero, s0_fire && (s0_mode_r == MODE_SAMPLE), !out_answer_r)
  // a was-pressed query leaves the queried edge cleared
  `DEAR_ASSERT_NEXT(a_was_clears, s0_fire && (s0_mode_r == MODE_WAS), (edge_r & $past(act_oh)) == '0)
  // a newly accepted press always raises its edge
  `DEAR_ASSERT_NOW(a_press_edge, 1'b1, ((stable_r & ~$past(stable_r) & ~edge_r) == '0))

endmodule

/* bench/debounce_edge_auto_repeat_test.sv */
import dear_pkg::*;

class dear_scoreboard;
  typedef struct {
    logic [1:0]       mode;
    logic [ACT_W-1:0] act;
    logic             answer;
  } answer_rec_t;

  logic [DBC_W-1:0] dbc_ms;
  logic [DLY_W-1:0] first_ms;
  logic [DLY_W-1:0] ivl_ms;

  logic  stable_lvl [NUM_ACT];
  logic  raw_lvl    [NUM_ACT];
  logic  press_seen [NUM_ACT];
  time_t change_at  [NUM_ACT];
  time_t press_at   [NUM_ACT];
  time_t fire_at    [NUM_ACT];

  answer_rec_t answers_due[$];
  int errors;

  function new();
    int i;
    dbc_ms   = K_DEBOUNCE_MS;
    first_ms = K_FIRST_DELAY;
    ivl_ms   = K_REPEAT_IVL;
    for (i = 0; i < NUM_ACT; i++) begin
      stable_lvl[i] = 1'b0;
      raw_lvl[i]    = 1'b0;
      press_seen[i] = 1'b0;
      change_at[i]  = '0;
      press_at[i]   = '0;
      fire_at[i]    = '0;
    end
    errors = 0;
  endfunction

  // wraps modulo 2^TIME_W
  function time_t ms_since(time_t now, time_t then);
    return now - then;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEBOUNCE:    dbc_ms = data[DBC_W-1:0];
      CFG_FIRST_DELAY: first_ms = data;
      CFG_REPEAT_IVL:  ivl_ms = data;
      default: ;
    endcase
  endfunction

  function void note_word(logic [1:0] mode, logic [2:0] dir, logic sw,
                          logic [ACT_W-1:0] act, time_t now);
    logic raw [NUM_ACT];
    answer_rec_t rec;
    int i;
    rec.mode   = mode;
    rec.act    = act;
    rec.answer = 1'b0;
    case (mode)
      MODE_SAMPLE: begin
        raw[ACT_UP]   = (dir == DIR_UP);
        raw[ACT_DOWN] = (dir == DIR_DOWN);
        raw[ACT_OK]   = (dir == DIR_RIGHT) || sw;
        raw[ACT_BACK] = (dir == DIR_LEFT);
        for (i = 0; i < NUM_ACT; i++) begin
          if (raw[i] != raw_lvl[i]) begin
            raw_lvl[i]   = raw[i];
            change_at[i] = now;
          end else if (ms_since(now, change_at[i]) >= time_t'(dbc_ms) &&
                       raw[i] != stable_lvl[i]) begin
            stable_lvl[i] = raw[i];
            if (raw[i]) begin
              press_seen[i] = 1'b1;
              press_at[i]   = now;
              fire_at[i]    = now;
            end
          end
        end
      end
      MODE_WAS: begin
        if (press_seen[act]) begin
          press_seen[act] = 1'b0;
          rec.answer      = 1'b1;
        end
      end
      MODE_REPEAT: begin
        if (press_seen[act]) begin
          press_seen[act] = 1'b0;
          fire_at[act]    = now;
          rec.answer      = 1'b1;
        end else if (stable_lvl[act] &&
                     ms_since(now, press_at[act]) >= time_t'(first_ms) &&
                     ms_since(now, fire_at[act]) >= time_t'(ivl_ms)) begin
          fire_at[act] = now;
          rec.answer   = 1'b1;
        end
      end
      MODE_IS: rec.answer = stable_lvl[act];
      default: ;
    endcase
    answers_due.push_back(rec);
  endfunction

  function void check_answer(logic got);
    answer_rec_t want;
    if (answers_due.size() == 0) begin
      flag($sformatf("unexpected answer %0b with nothing pending", got));
    end else begin
      want = answers_due.pop_front();
      if (got !== want.answer)
        flag($sformatf("answer mismatch: mode %0d action %0d expected %0b got %0b",
                       want.mode, want.act, want.answer, got));
    end
  endfunction

  function int pending();
    return answers_due.size();
  endfunction
endclass

module debounce_edge_auto_repeat_test;
  localparam logic [2:0]           DIR_CENTER   = 3'd0;
  localparam logic [2:0]           DIR_UNUSED_A = 3'd5;
  localparam logic [2:0]           DIR_UNUSED_B = 3'd6;
  localparam logic [2:0]           DIR_UNUSED_C = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
  localparam logic [ACT_W-1:0]     A_UP   = ACT_W'(ACT_UP);
  localparam logic [ACT_W-1:0]     A_DOWN = ACT_W'(ACT_DOWN);
  localparam logic [ACT_W-1:0]     A_OK   = ACT_W'(ACT_OK);
  localparam logic [ACT_W-1:0]     A_BACK = ACT_W'(ACT_BACK);
  localparam int LONG_HOLD      = 48;
  localparam int WATCHDOG_LIMIT = 500;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_mode = MODE_SAMPLE;
  logic [2:0]            in_direction = DIR_CENTER;
  logic                  in_switch_pressed = 1'b0;
  logic [ACT_W-1:0]      in_action = A_UP;
  time_t                 in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_answer;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dear_scoreboard sb;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  debounce_edge_auto_repeat DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_direction      (in_direction),
    .in_switch_pressed (in_switch_pressed),
    .in_action         (in_action),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_answer        (out_answer),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1)
        sb.note_word(in_mode, in_direction, in_switch_pressed, in_action, in_now_ms);
      if (out_valid === 1'b1 && out_ready)
        sb.check_answer(out_answer);
      if (cfg_valid && cfg_ready === 1'b1)
        sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
          (cfg_valid && cfg_ready === 1'b1))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random short stalls, one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [1:0] m, logic [2:0] d, logic s,
                           logic [ACT_W-1:0] a, time_t t);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_mode           <= m;
    in_direction      <= d;
    in_switch_pressed <= s;
    in_action         <= a;
    in_now_ms         <= t;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stick held for runs of words with samples and queries interleaved; a few
  // bounces, and a little noise with arbitrary fields and timestamps.
  task automatic run_phase(logic [DBC_W-1:0] dbc, logic [DLY_W-1:0] first,
                           logic [DLY_W-1:0] ivl, int words, time_t start,
                           bit squeeze, bit odd_write);
    time_t t;
    int step_max;
    int hold_left;
    int k;
    logic [2:0] dir;
    logic sw;
    t = start;
    hold_left = 0;
    dir = DIR_CENTER;
    sw = 1'b0;
    drain();
    cfg_write(CFG_DEBOUNCE, {8'($urandom), dbc});
    cfg_write(CFG_FIRST_DELAY, first);
    cfg_write(CFG_REPEAT_IVL, ivl);
    if (odd_write) cfg_write(CFG_UNUSED, 16'($urandom));
    step_max = 1 + int'(dbc) / 3 + int'(first) / 24 + int'(ivl) / 24;
    if (squeeze) hold_req = 1'b1;
    for (k = 0; k < words; k++) begin
      if (!calm && $urandom_range(0, 7) == 0) sender_gap();
      if ($urandom_range(0, 99) < 3) begin
        send_word(2'($urandom), 3'($urandom), 1'($urandom), ACT_W'($urandom), $urandom);
      end else begin
        if (hold_left == 0) begin
          dir = ($urandom_range(0, 9) < 4) ? DIR_CENTER : 3'($urandom_range(0, 7));
          sw = ($urandom_range(0, 3) == 0);
          hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 40);
        end
        hold_left--;
        t += time_t'($urandom_range(0, step_max));
        if ($urandom_range(0, 99) < 45)
          send_word(MODE_SAMPLE, dir, sw, ACT_W'($urandom), t);
        else
          send_word(2'($urandom_range(1, 3)), 3'($urandom), 1'($urandom),
                    ACT_W'($urandom), t);
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // power-up defaults: press, edge consume, hold-to-repeat, release
    send_word(MODE_SAMPLE, DIR_CENTER, 1'b0, A_UP, 32'd3);
    send_word(MODE_WAS, DIR_UNUSED_C, 1'b1, A_UP, 32'd4);
    send_word(MODE_SAMPLE, DIR_UP, 1'b0, A_BACK, 32'd100);
    send_word(MODE_SAMPLE, DIR_UP, 1'b0, A_UP, 32'd104);
    send_word(MODE_SAMPLE, DIR_UP, 1'b0, A_UP, 32'd108);
    send_word(MODE_IS, DIR_CENTER, 1'b0, A_UP, 32'd109);
    send_word(MODE_WAS, DIR_CENTER, 1'b0, A_UP, 32'd110);
    send_word(MODE_WAS, DIR_CENTER, 1'b0, A_UP, 32'd111);
    send_word(MODE_REPEAT, DIR_DOWN, 1'b1, A_UP, 32'd200);
    send_word(MODE_REPEAT, DIR_CENTER, 1'b0, A_UP, 32'd700);
    send_word(MODE_REPEAT, DIR_CENTER, 1'b0, A_UP, 32'd760);
    send_word(MODE_REPEAT, DIR_CENTER, 1'b0, A_UP, 32'd860);
    // unused direction codes count as centre
    send_word(MODE_SAMPLE, DIR_UNUSED_C, 1'b0, A_UP, 32'd900);
    send_word(MODE_SAMPLE, DIR_UNUSED_A, 1'b0, A_UP, 32'd910);
    send_word(MODE_IS, DIR_CENTER, 1'b0, A_UP, 32'd911);
    // ok from a right push, then kept by the switch alone
    send_word(MODE_SAMPLE, DIR_RIGHT, 1'b1, A_OK, 32'd920);
    send_word(MODE_SAMPLE, DIR_UNUSED_B, 1'b1, A_OK, 32'd930);
    send_word(MODE_REPEAT, DIR_CENTER, 1'b0, A_OK, 32'd931);
    // timestamp wrap, then a jump backwards
    send_word(MODE_SAMPLE, DIR_DOWN, 1'b0, A_DOWN, 32'hFFFF_FFFC);
    send_word(MODE_SAMPLE, DIR_DOWN, 1'b0, A_DOWN, 32'h0000_0004);
    send_word(MODE_WAS, DIR_CENTER, 1'b0, A_DOWN, 32'h0000_0005);
    send_word(MODE_SAMPLE, DIR_LEFT, 1'b0, A_BACK, 32'hFFFF_FFFF);
    send_word(MODE_SAMPLE, DIR_LEFT, 1'b0, A_BACK, 32'h7FFF_FFFF);
    send_word(MODE_IS, DIR_CENTER, 1'b0, A_BACK, 32'h0);
    send_word(MODE_IS, DIR_CENTER, 1'b0, A_OK, 32'h0);

    // zero timings: accept on first repeat, fire on every repeat query
    drain();
    cfg_write(CFG_DEBOUNCE, 16'h0000);
    cfg_write(CFG_FIRST_DELAY, 16'h0000);
    cfg_write(CFG_REPEAT_IVL, 16'h0000);
    send_word(MODE_SAMPLE, DIR_RIGHT, 1'b0, A_OK, 32'd50);
    send_word(MODE_SAMPLE, DIR_RIGHT, 1'b0, A_OK, 32'd50);
    send_word(MODE_REPEAT, DIR_CENTER, 1'b0, A_OK, 32'd50);
    send_word(MODE_REPEAT, DIR_CENTER, 1'b0, A_OK, 32'd50);

    run_phase(8'd0, 16'd0, 16'd0, 200, $urandom, 1'b0, 1'b0);
    run_phase(8'd255, 16'hFFFF, 16'hFFFF, 200,
              32'hFFFF_FFFF - time_t'($urandom_range(0, 3000)), 1'b1, 1'b0);
    run_phase(K_DEBOUNCE_MS, K_FIRST_DELAY, K_REPEAT_IVL, 200, $urandom, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 20)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 100)), 200, $urandom, 1'b0, 1'b1);
    run_phase(8'($urandom), 16'($urandom), 16'($urandom), 200, $urandom, 1'b0, 1'b0);
    run_phase(8'd1, 16'd1, 16'd1, 200, $urandom, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 20)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 100)), 200, $urandom, 1'b1, 1'b0);
    calm = 1'b1;
    run_phase(8'($urandom_range(0, 12)), 16'($urandom_range(0, 200)),
              16'($urandom_range(0, 60)), 200, $urandom, 1'b0, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/dear_pkg.sv
src/debounce_edge_auto_repeat.sv
bench/debounce_edge_auto_repeat_test.sv
